[sv/receive_window_reorder_top_defines.svh]
// Assertion macros shared by the receive window reorder RTL.
`ifndef RECEIVE_WINDOW_REORDER_TOP_DEFINES_SVH
`define RECEIVE_WINDOW_REORDER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RWR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RWR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RWR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`define RWR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[sv/rwr_pkg.sv]
// Shared types and constants for the receive window reorder block.
`default_nettype none

package rwr_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;

    localparam logic [16:0] HDR_BYTES    = 17'd56;
    localparam logic [16:0] IP_HDR_BYTES = 17'd20;
    localparam logic [6:0]  WL_RESET     = 7'd64;

    localparam logic CFG_WINDOW_LENGTH = 1'b0;
    localparam logic CFG_NO_IP_HEADER  = 1'b1;

    localparam logic FUNC_PACKET  = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        OC_IN_ORDER      = 3'd0,
        OC_OUT_OF_ORDER  = 3'd1,
        OC_DUPLICATE     = 3'd2,
        OC_OUTSIDE       = 3'd3,
        OC_TOO_SHORT     = 3'd4,
        OC_RELEASED      = 3'd5,
        OC_RELEASE_EMPTY = 3'd6
    } outcome_t;

    typedef struct packed {
        logic latch;
        logic eval;
        logic walk_rd;
        logic walk_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_order;
        logic walk_go;
    } dp_sts_t;

endpackage

`default_nettype wire

[sv/receive_window_reorder_top.sv]
// Receive window reorder buffer: packet words in, one status word out per item.
//
// Input channel s_*: one word per packet arrival (s_func = 0) or slot release
// (s_func = 1), valid/ready handshake. Output channel m_*: one result word per
// input word, in input order, valid/ready handshake.
// Configuration: cfg_wen writes cfg_wdata into register cfg_index (0 window
// length, 1 no IP header) on the clock edge; write only while the block is idle.
// An accepted word passes the evaluate and finish steps, the finish step loading its result into
// the output register; in-order arrivals walk in between, a read and a compare step per slot checked.
// The walk is bound by the single read port of the slot sequence memory.
// One word at a time: the next word is accepted the cycle after the previous result is
// loaded into the output register, even if that result still waits for m_ready.
// Reset (aresetn low, synchronous): all slots empty, expected sequence and read
// position zero, window length 64, no IP header cleared; s_ready comes up the
// cycle after reset is released.
// A stalled receiver holds the result word; processing of the following word
// halts at its finish step until the output register frees.
`default_nettype none

module receive_window_reorder_top #(
    parameter int WINDOW_DEPTH = rwr_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [15:0] s_packet_seq,
    input  wire logic [15:0] s_payload_length,
    input  wire logic [15:0] s_received_length,
    input  wire logic        s_is_data_packet,
    input  wire logic [31:0] s_payload_handle,
    input  wire logic [5:0]  s_release_slot,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_outcome,
    output logic [5:0]       m_slot_used,
    output logic [15:0]      m_expected_seq_now,
    output logic [5:0]       m_read_position_now,
    output logic [6:0]       m_waiting_count
);
    import rwr_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    rwr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rwr_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wen             (cfg_wen),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_func              (s_func),
        .s_packet_seq        (s_packet_seq),
        .s_payload_length    (s_payload_length),
        .s_received_length   (s_received_length),
        .s_is_data_packet    (s_is_data_packet),
        .s_payload_handle    (s_payload_handle),
        .s_release_slot      (s_release_slot),
        .m_outcome           (m_outcome),
        .m_slot_used         (m_slot_used),
        .m_expected_seq_now  (m_expected_seq_now),
        .m_read_position_now (m_read_position_now),
        .m_waiting_count     (m_waiting_count),
        .cmd                 (cmd),
        .sts                 (sts)
    );

endmodule

`default_nettype wire

[sv/rwr_ctrl.sv]
// Controller state machine: sequences accept, evaluate, walk and result load.
`default_nettype none

`include "receive_window_reorder_top_defines.svh"

module rwr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire rwr_pkg::dp_sts_t   sts,
    output rwr_pkg::ctrl_cmd_t      cmd
);
    import rwr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_WALK_RD,
        S_WALK_CMP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                // ready is low in the first idle cycle after reset
                if (s_valid && s_ready_reg) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.in_order ? S_WALK_RD : S_DONE;
            end
            S_WALK_RD: begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                if (sts.walk_go) begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // output register free or draining this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        s_ready_next = (state_next == S_IDLE);
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

    `RWR_ASSERT_IMPL(a_ready_only_idle, aclk, aresetn, s_ready_reg, state_reg == S_IDLE, "ready")

    `RWR_ASSERT_IMPL(a_latch_on_accept, aclk, aresetn, cmd.latch, s_valid && s_ready_reg, "latch")

    `RWR_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.load_out, m_valid_reg, "load lost")

    `RWR_ASSERT_NEXT(a_valid_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg, "drop")

endmodule

`default_nettype wire

[sv/rwr_datapath.sv]
// Datapath: item latch, window state, slot memories and result registers.
`default_nettype none

`include "receive_window_reorder_top_defines.svh"

module rwr_datapath #(
    parameter int WINDOW_DEPTH = rwr_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wen,
    input  wire logic               cfg_index,
    input  wire logic [6:0]         cfg_wdata,
    input  wire logic               s_func,
    input  wire logic [15:0]        s_packet_seq,
    input  wire logic [15:0]        s_payload_length,
    input  wire logic [15:0]        s_received_length,
    input  wire logic               s_is_data_packet,
    input  wire logic [31:0]        s_payload_handle,
    input  wire logic [5:0]         s_release_slot,
    output logic [2:0]              m_outcome,
    output logic [5:0]              m_slot_used,
    output logic [15:0]             m_expected_seq_now,
    output logic [5:0]              m_read_position_now,
    output logic [6:0]              m_waiting_count,
    input  wire rwr_pkg::ctrl_cmd_t cmd,
    output rwr_pkg::dp_sts_t        sts
);
    import rwr_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int EW = (CW > 7) ? CW : 7;

    // configuration
    logic [6:0] wl_reg;
    logic       no_ip_reg;

    // latched item
    logic        func_reg;
    logic [15:0] seq_reg;
    logic [15:0] plen_reg;
    logic [15:0] rlen_reg;
    logic        data_reg;
    logic [31:0] handle_reg;
    logic [5:0]  rs_reg;

    // window state
    logic [WINDOW_DEPTH-1:0] full_reg, full_next;
    logic [AW-1:0]           rp_reg, rp_next;
    logic [15:0]             exp_reg, exp_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           n_reg, n_next;
    outcome_t                outcome_reg, outcome_next;
    logic [AW-1:0]           used_reg, used_next;
    logic [15:0]             seq_rd_reg;

    // slot memories
    logic [15:0] seq_mem    [WINDOW_DEPTH];
    logic [15:0] length_mem [WINDOW_DEPTH];
    logic [31:0] handle_mem [WINDOW_DEPTH];

    // result registers
    outcome_t    res_outcome_reg;
    logic [AW-1:0] res_used_reg;
    logic [15:0] res_exp_reg;
    logic [AW-1:0] res_rp_reg;
    logic [CW-1:0] res_cnt_reg;

    logic [EW-1:0] win_eff;
    logic [EW-1:0] wl_ext;
    logic [AW-1:0] rp0;
    logic [16:0]   need_raw, need_even, need;
    logic          is_short;
    logic [EW-1:0] rs_ext;
    logic          rs_ok;
    logic [AW-1:0] rs_idx;
    logic [15:0]   seq_gap;
    logic          in_win;
    logic [EW:0]   psum;
    logic [AW-1:0] pos;
    logic          store_en;
    logic [AW-1:0] store_idx;

    function automatic logic [AW-1:0] rp_inc(input logic [AW-1:0] rp, input logic [EW-1:0] w);
        logic [EW-1:0] adv;
        adv = EW'(rp) + EW'(1);
        rp_inc = (adv >= w) ? '0 : adv[AW-1:0];
    endfunction

    always_comb begin
        wl_ext = EW'(wl_reg);
        if (wl_ext == '0) begin
            win_eff = EW'(1);
        end else if (wl_ext > EW'(WINDOW_DEPTH)) begin
            win_eff = EW'(WINDOW_DEPTH);
        end else begin
            win_eff = wl_ext;
        end
        rp0 = (EW'(rp_reg) >= win_eff) ? '0 : rp_reg;

        // 56 header bytes plus payload, rounded up to even, less 20 IP header bytes when no IP header is set
        need_raw  = HDR_BYTES + {1'b0, plen_reg};
        need_even = need_raw + {16'b0, need_raw[0]};
        need      = no_ip_reg ? (need_even - IP_HDR_BYTES) : need_even;
        is_short  = ({1'b0, rlen_reg} < need);

        rs_ext = EW'(rs_reg);
        rs_ok  = rs_ext < EW'(WINDOW_DEPTH);
        rs_idx = rs_ext[AW-1:0];

        seq_gap = seq_reg - exp_reg;
        in_win  = seq_gap < 16'(win_eff);
        psum    = {1'b0, EW'(rp0)} + {1'b0, EW'(seq_gap)};
        if (psum >= {1'b0, win_eff}) begin
            psum = psum - {1'b0, win_eff};
        end
        pos = psum[AW-1:0];
    end

    assign sts.in_order = (func_reg == FUNC_PACKET) && !is_short && (seq_reg == exp_reg);
    assign sts.walk_go  = full_reg[rp_reg] && (seq_rd_reg == exp_reg) && (EW'(n_reg) < win_eff);

    always_comb begin
        full_next    = full_reg;
        rp_next      = rp_reg;
        exp_next     = exp_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        outcome_next = outcome_reg;
        used_next    = used_reg;
        store_en     = 1'b0;
        store_idx    = rp0;

        if (cmd.eval) begin
            rp_next   = rp0;
            used_next = '0;
            n_next    = '0;
            if (func_reg == FUNC_RELEASE) begin
                if (rs_ok && full_reg[rs_idx]) begin
                    full_next[rs_idx] = 1'b0;
                    if (cnt_reg != '0) begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                    outcome_next = OC_RELEASED;
                    used_next    = rs_idx;
                end else begin
                    outcome_next = OC_RELEASE_EMPTY;
                end
            end else if (is_short) begin
                outcome_next = OC_TOO_SHORT;
            end else if (seq_reg == exp_reg) begin
                if (!full_reg[rp0] && data_reg) begin
                    store_en     = 1'b1;
                    store_idx    = rp0;
                    used_next    = rp0;
                    outcome_next = OC_IN_ORDER;
                    rp_next      = rp_inc(rp0, win_eff);
                end else begin
                    outcome_next = OC_DUPLICATE;
                end
                exp_next = exp_reg + 16'd1;
            end else if (in_win) begin
                if (!full_reg[pos]) begin
                    store_en     = 1'b1;
                    store_idx    = pos;
                    used_next    = pos;
                    outcome_next = OC_OUT_OF_ORDER;
                end else begin
                    outcome_next = OC_DUPLICATE;
                end
            end else begin
                outcome_next = OC_OUTSIDE;
            end
            if (store_en) begin
                full_next[store_idx] = 1'b1;
                cnt_next             = cnt_reg + CW'(1);
            end
        end else if (cmd.walk_step) begin
            exp_next = exp_reg + 16'd1;
            rp_next  = rp_inc(rp_reg, win_eff);
            n_next   = n_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg      <= WL_RESET;
            no_ip_reg   <= 1'b0;
            full_reg    <= '0;
            rp_reg      <= '0;
            exp_reg     <= '0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            outcome_reg <= OC_IN_ORDER;
            used_reg    <= '0;
        end else begin
            if (cfg_wen) begin
                if (cfg_index == CFG_WINDOW_LENGTH) begin
                    wl_reg <= cfg_wdata;
                end else begin
                    no_ip_reg <= cfg_wdata[0];
                end
            end
            full_reg    <= full_next;
            rp_reg      <= rp_next;
            exp_reg     <= exp_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            outcome_reg <= outcome_next;
            used_reg    <= used_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            func_reg   <= s_func;
            seq_reg    <= s_packet_seq;
            plen_reg   <= s_payload_length;
            rlen_reg   <= s_received_length;
            data_reg   <= s_is_data_packet;
            handle_reg <= s_payload_handle;
            rs_reg     <= s_release_slot;
        end
        if (cmd.load_out) begin
            res_outcome_reg <= outcome_reg;
            res_used_reg    <= used_reg;
            res_exp_reg     <= exp_reg;
            res_rp_reg      <= rp_reg;
            res_cnt_reg     <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            seq_mem[store_idx]    <= seq_reg;
            length_mem[store_idx] <= plen_reg;
            handle_mem[store_idx] <= handle_reg;
        end
        if (cmd.walk_rd) begin
            seq_rd_reg <= seq_mem[rp_reg];
        end
    end

    assign m_outcome           = res_outcome_reg;
    assign m_slot_used         = 6'(res_used_reg);
    assign m_expected_seq_now  = res_exp_reg;
    assign m_read_position_now = 6'(res_rp_reg);
    assign m_waiting_count     = 7'(res_cnt_reg);

    `RWR_ASSERT_IMPL(a_cnt_full, aclk, aresetn, 1'b1, cnt_reg == CW'($countones(full_reg)), "count")

    `RWR_ASSERT_NEXT(a_rp_eval, aclk, aresetn, cmd.eval, EW'(rp_reg) < $past(win_eff), "rp eval")

    `RWR_ASSERT_NEXT(a_rp_walk, aclk, aresetn, cmd.walk_step, EW'(rp_reg) < $past(win_eff), "rp walk")

endmodule

`default_nettype wire
